FILE: src/cst_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the counting semaphore table.
// No dependencies; used by counting_semaphore_table and the testbench.
package cst_pkg;

  localparam int NUM_SEMAPHORES  = 16;
  localparam int WAITER_DEPTH    = 16;
  localparam int PROCESS_ID_BITS = 8;

  localparam int SEM_BITS    = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int QHEAD_BITS  = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
  localparam int WAITER_ENTRIES = NUM_SEMAPHORES * WAITER_DEPTH;
  localparam int WADDR_BITS  = (WAITER_ENTRIES > 1) ? $clog2(WAITER_ENTRIES) : 1;
  localparam int WLEFT_BITS  = $clog2(WAITER_DEPTH + 1);
  localparam int COUNT_BITS  = 9;
  localparam int SEM_WORD_BITS = COUNT_BITS + QHEAD_BITS;

  typedef logic signed [COUNT_BITS-1:0] count_t;

  localparam count_t COUNT_MAX = count_t'(255);
  localparam count_t COUNT_MIN = count_t'(-WAITER_DEPTH);

  localparam logic [1:0] OP_INIT    = 2'd0;
  localparam logic [1:0] OP_WAIT    = 2'd1;
  localparam logic [1:0] OP_POST    = 2'd2;
  localparam logic [1:0] OP_DESTROY = 2'd3;

  localparam logic [2:0] KIND_GRANTED = 3'd0;
  localparam logic [2:0] KIND_BLOCKED = 3'd1;
  localparam logic [2:0] KIND_NOSEM   = 3'd2;
  localparam logic [2:0] KIND_FULL    = 3'd3;
  localparam logic [2:0] KIND_ACK     = 3'd4;
  localparam logic [2:0] KIND_WAKE    = 3'd5;

endpackage

FILE: src/cst_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/counting_semaphore_table.sv
`timescale 1ns / 1ps
// Counting semaphore table with a FIFO of waiting process ids per semaphore.
// Depends on cst_pkg and cst_ram.
//
//  Channel  Direction  Ports                       Contents
//  in_      slave      tvalid/tready/tdata/tuser   one request
//  out_     master     tvalid/tready/tdata/tuser/  one result, tlast on the final
//                      tlast                       result of a request
//
// Init, wait and post without a waiter: accept with the count/head RAM read, then
// execute and write back. Post that wakes a waiter reads its id, wakes it and acks;
// destroy reads and wakes each waiter, then acks, paced by the waiter RAM read port.
// Reset clears the presence bits in flip-flops; no clearing pass is needed.
// A stalled output holds the request in its current step; input is taken only
// when the previous request has handed its last result to the output register.
module counting_semaphore_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] sem_index, [11:4] process, [19:12] init_value
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] target_process
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_ACK  = 3'd4;

  // request registers
  logic [2:0]                           state_r, state_nxt;
  logic [1:0]                           op_r;
  logic [cst_pkg::SEM_BITS-1:0]         idx_r;
  logic                                 in_range_r;
  logic [cst_pkg::PROCESS_ID_BITS-1:0]  proc_r;
  logic [7:0]                           ival_r;
  logic [cst_pkg::NUM_SEMAPHORES-1:0]   present_r, present_nxt;
  logic [cst_pkg::QHEAD_BITS-1:0]       walk_pos_r, walk_pos_nxt;
  logic [cst_pkg::WLEFT_BITS-1:0]       walk_left_r, walk_left_nxt;

  // output register
  logic       out_valid_r;
  logic [2:0] out_kind_r;
  logic [7:0] out_proc_r;
  logic       out_last_r;

  logic       in_fire;
  logic       out_load;
  logic       emit_v;
  logic [2:0] emit_kind;
  logic [7:0] emit_proc;
  logic       emit_last;

  // memories
  logic                                sem_wr_en;
  logic [cst_pkg::SEM_WORD_BITS-1:0]   sem_wr_data;
  logic [cst_pkg::SEM_WORD_BITS-1:0]   sem_rd_data;
  logic                                wt_wr_en;
  logic [cst_pkg::WADDR_BITS-1:0]      wt_wr_addr;
  logic                                wt_rd_en;
  logic [cst_pkg::WADDR_BITS-1:0]      wt_rd_addr;
  logic [cst_pkg::PROCESS_ID_BITS-1:0] wt_rd_data;

  cst_pkg::count_t                     count_q, count_new;
  logic [cst_pkg::QHEAD_BITS-1:0]      head_q, head_new;
  logic [cst_pkg::COUNT_BITS-1:0]      waiters;
  logic                                exists;

  function automatic logic [cst_pkg::QHEAD_BITS-1:0] queue_wrap(
    input logic [cst_pkg::QHEAD_BITS:0] sum
  );
    logic [cst_pkg::QHEAD_BITS:0] depth;
    depth = (cst_pkg::QHEAD_BITS+1)'(cst_pkg::WAITER_DEPTH);
    if (sum >= depth) begin
      return cst_pkg::QHEAD_BITS'(sum - depth);
    end
    return cst_pkg::QHEAD_BITS'(sum);
  endfunction

  function automatic logic [cst_pkg::WADDR_BITS-1:0] waiter_addr(
    input logic [cst_pkg::SEM_BITS-1:0]   sem,
    input logic [cst_pkg::QHEAD_BITS-1:0] pos
  );
    return cst_pkg::WADDR_BITS'(32'(sem) * cst_pkg::WAITER_DEPTH + 32'(pos));
  endfunction

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = !out_valid_r || out_tready;

  assign count_q = cst_pkg::count_t'(sem_rd_data[cst_pkg::SEM_WORD_BITS-1:cst_pkg::QHEAD_BITS]);
  assign head_q  = sem_rd_data[cst_pkg::QHEAD_BITS-1:0];
  assign waiters = cst_pkg::COUNT_BITS'(-count_q);
  assign exists  = in_range_r && present_r[idx_r];

  cst_ram #(
    .WIDTH (cst_pkg::SEM_WORD_BITS),
    .DEPTH (cst_pkg::NUM_SEMAPHORES)
  ) u_sem_ram (
    .clk     (clk),
    .wr_en   (sem_wr_en),
    .wr_addr (idx_r),
    .wr_data (sem_wr_data),
    .rd_en   (in_fire),
    .rd_addr (cst_pkg::SEM_BITS'(in_tdata[3:0])),
    .rd_data (sem_rd_data)
  );

  cst_ram #(
    .WIDTH (cst_pkg::PROCESS_ID_BITS),
    .DEPTH (cst_pkg::WAITER_ENTRIES)
  ) u_waiter_ram (
    .clk     (clk),
    .wr_en   (wt_wr_en),
    .wr_addr (wt_wr_addr),
    .wr_data (proc_r),
    .rd_en   (wt_rd_en),
    .rd_addr (wt_rd_addr),
    .rd_data (wt_rd_data)
  );

  assign sem_wr_data = {count_new, head_new};
  assign wt_rd_addr  = waiter_addr(idx_r, walk_pos_r);
  assign wt_rd_en    = (state_r == ST_RD);

  always_comb begin
    state_nxt     = state_r;
    present_nxt   = present_r;
    walk_pos_nxt  = walk_pos_r;
    walk_left_nxt = walk_left_r;
    emit_v        = 1'b0;
    emit_kind     = cst_pkg::KIND_ACK;
    emit_proc     = 8'd0;
    emit_last     = 1'b1;
    sem_wr_en     = 1'b0;
    count_new     = count_q;
    head_new      = head_q;
    wt_wr_en      = 1'b0;
    wt_wr_addr    = waiter_addr(idx_r,
                      queue_wrap({1'b0, head_q} + (cst_pkg::QHEAD_BITS+1)'(waiters)));

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (op_r)
          cst_pkg::OP_INIT: begin
            emit_v = 1'b1;
            if (out_load) begin
              state_nxt = ST_IDLE;
              if (in_range_r && !present_r[idx_r]) begin
                present_nxt[idx_r] = 1'b1;
                sem_wr_en          = 1'b1;
                count_new          = cst_pkg::count_t'({1'b0, ival_r});
                head_new           = '0;
              end
            end
          end

          cst_pkg::OP_WAIT: begin
            emit_v    = 1'b1;
            emit_proc = 8'(proc_r);
            if (!exists) begin
              emit_kind = cst_pkg::KIND_NOSEM;
            end else if (count_q > 0) begin
              emit_kind = cst_pkg::KIND_GRANTED;
              count_new = count_q - cst_pkg::count_t'(1);
              sem_wr_en = out_load;
            end else if (32'(waiters) >= cst_pkg::WAITER_DEPTH) begin
              emit_kind = cst_pkg::KIND_FULL;
            end else begin
              emit_kind = cst_pkg::KIND_BLOCKED;
              count_new = count_q - cst_pkg::count_t'(1);
              sem_wr_en = out_load;
              wt_wr_en  = out_load;
            end
            if (out_load) begin
              state_nxt = ST_IDLE;
            end
          end

          cst_pkg::OP_POST: begin
            if (exists && count_q < 0) begin
              // pop the head waiter now, read its id in the walk
              sem_wr_en     = 1'b1;
              count_new     = count_q + cst_pkg::count_t'(1);
              head_new      = queue_wrap({1'b0, head_q} + 1'b1);
              walk_pos_nxt  = head_q;
              walk_left_nxt = cst_pkg::WLEFT_BITS'(1);
              state_nxt     = ST_RD;
            end else begin
              emit_v = 1'b1;
              if (out_load) begin
                state_nxt = ST_IDLE;
                if (exists && count_q < cst_pkg::COUNT_MAX) begin
                  sem_wr_en = 1'b1;
                  count_new = count_q + cst_pkg::count_t'(1);
                end
              end
            end
          end

          cst_pkg::OP_DESTROY: begin
            if (!exists) begin
              emit_v    = 1'b1;
              emit_kind = cst_pkg::KIND_NOSEM;
              if (out_load) begin
                state_nxt = ST_IDLE;
              end
            end else begin
              present_nxt[idx_r] = 1'b0;
              walk_pos_nxt       = head_q;
              if (count_q < 0) begin
                walk_left_nxt = (32'(waiters) > cst_pkg::WAITER_DEPTH) ?
                                cst_pkg::WLEFT_BITS'(cst_pkg::WAITER_DEPTH) :
                                cst_pkg::WLEFT_BITS'(waiters);
                state_nxt     = ST_RD;
              end else begin
                walk_left_nxt = '0;
                state_nxt     = ST_ACK;
              end
            end
          end

          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_RD: begin
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        emit_v    = 1'b1;
        emit_kind = cst_pkg::KIND_WAKE;
        emit_proc = 8'(wt_rd_data);
        emit_last = 1'b0;
        if (out_load) begin
          walk_pos_nxt  = queue_wrap({1'b0, walk_pos_r} + 1'b1);
          walk_left_nxt = walk_left_r - 1'b1;
          state_nxt     = (walk_left_r == cst_pkg::WLEFT_BITS'(1)) ? ST_ACK : ST_RD;
        end
      end

      ST_ACK: begin
        emit_v = 1'b1;
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      present_r <= present_nxt;
      if (out_load) begin
        out_valid_r <= emit_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r       <= in_tuser;
      idx_r      <= cst_pkg::SEM_BITS'(in_tdata[3:0]);
      in_range_r <= (32'(in_tdata[3:0]) < cst_pkg::NUM_SEMAPHORES);
      proc_r     <= cst_pkg::PROCESS_ID_BITS'(in_tdata[11:4]);
      ival_r     <= in_tdata[19:12];
    end
    walk_pos_r  <= walk_pos_nxt;
    walk_left_r <= walk_left_nxt;
    if (out_load && emit_v) begin
      out_kind_r <= emit_kind;
      out_proc_r <= emit_proc;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_proc_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // walk steps always have a waiter left to read
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD || state_r == ST_EMIT) |-> (walk_left_r != '0))
    else $error("waiter walk running with nothing left");

  // a destroyed semaphore is already gone while its waiters are woken
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RD || state_r == ST_EMIT || state_r == ST_ACK) &&
     op_r == cst_pkg::OP_DESTROY) |-> !present_r[idx_r])
    else $error("destroyed semaphore still marked present");

  // a live count never drops below minus the queue depth
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && exists) |-> (count_q >= cst_pkg::COUNT_MIN))
    else $error("semaphore count below queue depth");

  // loading the final result of a request returns the sequencer to idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && emit_v && emit_last) |=> (state_r == ST_IDLE))
    else $error("final result without return to idle");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for counting_semaphore_table: queue-fed stream driver, result monitor
// and a transaction-level predictor of the semaphore slots and their waiter FIFOs.
// Depends on cst_pkg and the counting_semaphore_table RTL.
module testbench;

  localparam int RANDOM_ITEMS = 92;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [1:0] op;
    logic [3:0] sem;
    logic [7:0] proc;
    logic [7:0] init_val;
    bit         hold_for_drain;
    int         phase;
  } sem_request_t;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] proc;
    logic       last;
  } sem_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;  // [3:0] sem_index, [11:4] process, [19:12] init_value
  logic [1:0]  in_tuser   = '0;  // [1:0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // [7:0] target_process
  logic [2:0]  out_tuser;        // [2:0] kind
  logic        out_tlast;

  sem_request_t pending_requests[$];
  sem_result_t  expected_results[$];
  sem_request_t active_request;

  // predictor copy of the slot state
  bit          slot_live    [cst_pkg::NUM_SEMAPHORES];
  int          slot_count   [cst_pkg::NUM_SEMAPHORES];
  int          slot_head    [cst_pkg::NUM_SEMAPHORES];
  logic [7:0]  slot_waiters [cst_pkg::NUM_SEMAPHORES][cst_pkg::WAITER_DEPTH];

  int cur_phase;
  int cycles;
  int mismatches;
  int requests_taken;
  int results_checked;
  int wakes_seen;
  int full_seen;

  counting_semaphore_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_result(logic [2:0] kind, logic [7:0] proc, logic last);
    sem_result_t r;
    r.kind = kind;
    r.proc = proc;
    r.last = last;
    expected_results.push_back(r);
  endfunction

  // Apply one accepted request to the slot state and queue the results it causes.
  function automatic void predict_semaphore(sem_request_t req);
    int s;
    int n;
    s = int'(req.sem);
    case (req.op)
      cst_pkg::OP_INIT: begin
        if (!slot_live[s]) begin
          slot_live[s]  = 1'b1;
          slot_count[s] = int'(req.init_val);
          slot_head[s]  = 0;
        end
        push_result(cst_pkg::KIND_ACK, 8'd0, 1'b1);
      end
      cst_pkg::OP_WAIT: begin
        if (!slot_live[s]) begin
          push_result(cst_pkg::KIND_NOSEM, req.proc, 1'b1);
        end else if (slot_count[s] > 0) begin
          slot_count[s]--;
          push_result(cst_pkg::KIND_GRANTED, req.proc, 1'b1);
        end else if (-slot_count[s] >= cst_pkg::WAITER_DEPTH) begin
          push_result(cst_pkg::KIND_FULL, req.proc, 1'b1);
        end else begin
          slot_waiters[s][(slot_head[s] - slot_count[s]) % cst_pkg::WAITER_DEPTH] = req.proc;
          slot_count[s]--;
          push_result(cst_pkg::KIND_BLOCKED, req.proc, 1'b1);
        end
      end
      cst_pkg::OP_POST: begin
        if (slot_live[s]) begin
          if (slot_count[s] < 0) begin
            push_result(cst_pkg::KIND_WAKE, slot_waiters[s][slot_head[s]], 1'b0);
            slot_head[s] = (slot_head[s] + 1) % cst_pkg::WAITER_DEPTH;
            slot_count[s]++;
          end else if (slot_count[s] < int'(cst_pkg::COUNT_MAX)) begin
            slot_count[s]++;
          end
        end
        push_result(cst_pkg::KIND_ACK, 8'd0, 1'b1);
      end
      default: begin
        if (!slot_live[s]) begin
          push_result(cst_pkg::KIND_NOSEM, 8'd0, 1'b1);
        end else begin
          n = (slot_count[s] < 0) ? -slot_count[s] : 0;
          for (int i = 0; i < n; i++)
            push_result(cst_pkg::KIND_WAKE,
                        slot_waiters[s][(slot_head[s] + i) % cst_pkg::WAITER_DEPTH], 1'b0);
          push_result(cst_pkg::KIND_ACK, 8'd0, 1'b1);
          slot_live[s]  = 1'b0;
          slot_count[s] = 0;
          slot_head[s]  = 0;
        end
      end
    endcase
  endfunction

  function automatic void add_request(logic [1:0] op, logic [3:0] sem, logic [7:0] proc,
                                      logic [7:0] init_val, int phase, bit hold);
    sem_request_t req;
    req.op             = op;
    req.sem            = sem;
    req.proc           = proc;
    req.init_val       = init_val;
    req.phase          = phase;
    req.hold_for_drain = hold;
    pending_requests.push_back(req);
  endfunction

  function automatic int tx_idle_pct(int phase);
    return (phase == 0) ? 21 : (phase == 1) ? 55 : 0;
  endfunction

  function automatic int rx_stall_pct(int phase);
    return (phase == 0) ? 55 : (phase == 1) ? 21 : 0;
  endfunction

  // Driver: keep valid up until the transaction is taken, then maybe idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_semaphore(active_request);
        requests_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_requests.size() > 0 &&
            !(pending_requests[0].hold_for_drain && expected_results.size() > 0) &&
            $urandom_range(0, 99) >= tx_idle_pct(pending_requests[0].phase)) begin
          active_request = pending_requests.pop_front();
          cur_phase      = active_request.phase;
          in_tvalid <= 1'b1;
          in_tdata  <= {4'd0, active_request.init_val, active_request.proc, active_request.sem};
          in_tuser  <= active_request.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_checked++;
        if (out_tuser == cst_pkg::KIND_WAKE) wakes_seen++;
        if (out_tuser == cst_pkg::KIND_FULL) full_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] unexpected result: kind=%0d proc=0x%02h last=%0b",
                     $realtime, out_tuser, out_tdata, out_tlast);
        end else if (out_tuser !== expected_results[0].kind ||
                     out_tdata !== expected_results[0].proc ||
                     out_tlast !== expected_results[0].last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"[%0t] result mismatch: expected kind=%0d proc=0x%02h last=%0b, ",
                      "got kind=%0d proc=0x%02h last=%0b"},
                     $realtime, expected_results[0].kind, expected_results[0].proc,
                     expected_results[0].last, out_tuser, out_tdata, out_tlast);
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
      out_tready <= ($urandom_range(0, 99) >= rx_stall_pct(cur_phase));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int made;
    int phase;
    int burst;
    int pick;
    logic [3:0] sem;
    logic [7:0] ival;

    cur_phase = 0;

    // Directed: missing slot, re-init, saturation, full queue, head wrap, full destroy.
    add_request(cst_pkg::OP_WAIT,    4'd0,  8'hFF, 8'h00, 0, 1'b0);
    add_request(cst_pkg::OP_DESTROY, 4'd0,  8'h00, 8'hFF, 0, 1'b0);
    add_request(cst_pkg::OP_POST,    4'd0,  8'h5A, 8'h00, 0, 1'b0);
    add_request(cst_pkg::OP_INIT,    4'd0,  8'h00, 8'hFF, 0, 1'b0);
    add_request(cst_pkg::OP_INIT,    4'd0,  8'hFF, 8'h00, 0, 1'b0);
    add_request(cst_pkg::OP_POST,    4'd0,  8'h00, 8'h00, 0, 1'b0);
    add_request(cst_pkg::OP_WAIT,    4'd0,  8'h00, 8'h00, 0, 1'b0);
    add_request(cst_pkg::OP_INIT,    4'd15, 8'hAA, 8'h00, 0, 1'b0);
    for (int i = 0; i < cst_pkg::WAITER_DEPTH + 1; i++)
      add_request(cst_pkg::OP_WAIT, 4'd15, 8'(8'h80 + i), 8'h00, 0, 1'b0);
    add_request(cst_pkg::OP_POST,    4'd15, 8'h00, 8'h00, 0, 1'b0);
    add_request(cst_pkg::OP_WAIT,    4'd15, 8'h7F, 8'h00, 0, 1'b0);
    // hold the sender until every earlier result is back
    add_request(cst_pkg::OP_DESTROY, 4'd15, 8'h00, 8'h00, 0, 1'b1);

    // Random: mostly a few busy slots, with bursts of waits to fill queues.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      phase = made * 3 / RANDOM_ITEMS;
      sem   = ($urandom_range(0, 99) < 70) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
      if ($urandom_range(0, 99) < 12) begin
        burst = $urandom_range(4, cst_pkg::WAITER_DEPTH + 2);
        for (int i = 0; i < burst; i++)
          add_request(cst_pkg::OP_WAIT, sem, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), phase, 1'b0);
        made += burst;
      end else begin
        pick = $urandom_range(0, 99);
        ival = (pick < 50) ? 8'($urandom_range(0, 3)) :
               (pick < 80) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(254, 255));
        pick = $urandom_range(0, 99);
        add_request((pick < 15) ? cst_pkg::OP_INIT : (pick < 55) ? cst_pkg::OP_WAIT :
                    (pick < 90) ? cst_pkg::OP_POST : cst_pkg::OP_DESTROY,
                    sem, 8'($urandom_range(0, 255)), ival,
                    phase, (made * 3 / RANDOM_ITEMS) != ((made + 1) * 3 / RANDOM_ITEMS));
        made++;
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);

    if (expected_results.size() > 0) begin
      mismatches += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end
    $display("Covered %0d requests and %0d results on %0d slots of depth %0d",
             requests_taken, results_checked, cst_pkg::NUM_SEMAPHORES, cst_pkg::WAITER_DEPTH);
    $display("Wake results: %0d, queue-full results: %0d, mismatches: %0d",
             wakes_seen, full_seen, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/cst_pkg.sv
src/cst_ram.sv
src/counting_semaphore_table.sv
dv/testbench.sv
